// ===== hw/rtl/u8d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_pkg
// Shared types and constants of the UTF-8 to UTF-16 stream decoder.
// ----------------------------------------------------------------------------
package u8d_pkg;

    localparam int BYTE_W      = 8;
    localparam int CP_W        = 31;
    localparam int UNIT_W      = 16;
    localparam int LEFT_W      = 3;
    localparam int ONES_W      = 3;
    localparam int CONT_BITS   = 6;

    localparam logic [UNIT_W-1:0] STRAY_UNIT_HIGH = 16'hFF00;
    localparam logic [BYTE_W-1:0] LEAD_PAYLOAD    = 8'h7F;

    // leading-one count of a lead byte; both invalid leads fold into one code
    localparam logic [ONES_W-1:0] ONES_ASCII   = 3'd0;
    localparam logic [ONES_W-1:0] ONES_CONT    = 3'd1;
    localparam logic [ONES_W-1:0] ONES_INVALID = 3'd7;

    // decoder state carried between words
    typedef struct packed {
        logic [CP_W-1:0]   partial_point;
        logic [LEFT_W-1:0] bytes_left;
    } state_t;

    // one result word
    typedef struct packed {
        logic [CP_W-1:0]   code_point;
        logic [UNIT_W-1:0] utf16_unit;
        logic              stray_byte;
    } result_t;

    // decoder step outcome
    typedef struct packed {
        logic    emit;
        result_t result;
        state_t  state_next;
    } step_t;

endpackage

// ===== hw/rtl/u8d_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_in_if
// Input byte channel: valid/ready handshake carrying one UTF-8 byte.
// ----------------------------------------------------------------------------
interface u8d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

// ===== hw/rtl/u8d_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_out_if
// Result channel: valid/ready handshake carrying one decoded code point.
// ----------------------------------------------------------------------------
interface u8d_out_if;
    logic        valid;
    logic        ready;
    logic [30:0] code_point;
    logic [15:0] utf16_unit;
    logic        stray_byte;

    modport source (output valid, output code_point, output utf16_unit,
                    output stray_byte, input ready);
    modport sink   (input valid, input code_point, input utf16_unit,
                    input stray_byte, output ready);
endinterface

// ===== hw/rtl/utf8_to_utf16_stream_decoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_stream_decoder_core
// UTF-8 byte stream to code point / UTF-16 unit decoder.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch takes one UTF-8 byte per word. out_ch gives one word per complete
//   code point: the point, its low 16 bits as a UTF-16 unit (no surrogates),
//   and a stray flag for a lone continuation byte or lead 0xFE / 0xFF, which
//   come out alone with unit 0xFF00 or the byte.
//   Results: the byte that completes a result is decoded into the output
//   register, or into the skid register while the output word is not taken.
//   Throughput: one byte per cycle while in_ch.ready is high; the decode is
//   a single shift-and-mask step between the sequence state register and the
//   output register. Stalls: a two-entry output buffer lets one more result
//   in while one waits; in_ch.ready drops only when both entries are full.
//   Reset: clears any open sequence and empties the output buffer. A
//   sequence cut off at end of stream yields no word and stays open.
// ----------------------------------------------------------------------------
module utf8_to_utf16_stream_decoder_core
    import u8d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    u8d_in_if.sink     in_ch,
    u8d_out_if.source  out_ch
);

    state_t  state_reg;
    state_t  state_next;
    step_t   step;
    result_t out_data;
    logic    accept;
    logic    space;

    assign in_ch.ready = space;
    assign accept      = in_ch.valid && space;

    // per-byte decode
    u8d_decode u_decode (
        .in_byte (in_ch.in_byte),
        .state   (state_reg),
        .step    (step)
    );

    // sequence state update
    assign state_next = accept ? step.state_next : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // result buffering
    u8d_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept && step.emit),
        .push_data (step.result),
        .space     (space),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_data  (out_data)
    );

    assign out_ch.code_point = out_data.code_point;
    assign out_ch.utf16_unit = out_data.utf16_unit;
    assign out_ch.stray_byte = out_data.stray_byte;

endmodule

// ===== hw/rtl/u8d_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_decode
// Combinational decode of one byte against the open-sequence state.
// ----------------------------------------------------------------------------
module u8d_decode
    import u8d_pkg::*;
(
    input  logic [BYTE_W-1:0] in_byte,
    input  state_t            state,
    output step_t             step
);

    logic [ONES_W-1:0] ones;
    logic [CP_W-1:0]   shifted;
    logic [BYTE_W-1:0] lead_mask;

    // leading-one count of the byte
    always_comb
    begin
        priority casez (in_byte)
            8'b0???????: ones = ONES_ASCII;
            8'b10??????: ones = ONES_CONT;
            8'b110?????: ones = 3'd2;
            8'b1110????: ones = 3'd3;
            8'b11110???: ones = 3'd4;
            8'b111110??: ones = 3'd5;
            8'b1111110?: ones = 3'd6;
            default:     ones = ONES_INVALID;
        endcase
    end

    // continuation payload shifted into the partial point
    assign shifted   = {state.partial_point[CP_W-CONT_BITS-1:0], in_byte[CONT_BITS-1:0]};
    assign lead_mask = LEAD_PAYLOAD >> ones;

    // next state and result
    always_comb
    begin
        step = '0;
        step.state_next = state;
        if (state.bytes_left != '0)
        begin
            if (state.bytes_left == LEFT_W'(1))
            begin
                step.emit                 = 1'b1;
                step.result.code_point    = shifted;
                step.result.utf16_unit    = shifted[UNIT_W-1:0];
                step.result.stray_byte    = 1'b0;
                step.state_next.partial_point = '0;
                step.state_next.bytes_left    = '0;
            end
            else
            begin
                step.state_next.partial_point = shifted;
                step.state_next.bytes_left    = state.bytes_left - LEFT_W'(1);
            end
        end
        else if (ones == ONES_ASCII)
        begin
            step.emit              = 1'b1;
            step.result.code_point = CP_W'(in_byte);
            step.result.utf16_unit = UNIT_W'(in_byte);
            step.result.stray_byte = 1'b0;
        end
        else if (ones == ONES_CONT || ones == ONES_INVALID)
        begin
            step.emit              = 1'b1;
            step.result.code_point = CP_W'(in_byte);
            step.result.utf16_unit = STRAY_UNIT_HIGH | UNIT_W'(in_byte);
            step.result.stray_byte = 1'b1;
        end
        else
        begin
            step.state_next.partial_point = CP_W'(in_byte & lead_mask);
            step.state_next.bytes_left    = LEFT_W'(ones - ONES_W'(1));
        end
    end

endmodule

// ===== hw/rtl/u8d_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8d_out_buf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module u8d_out_buf
    import u8d_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    space,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    main_valid_reg;
    logic    main_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t main_data_reg;
    result_t main_data_next;
    result_t skid_data_reg;
    result_t skid_data_next;
    logic    main_free;

    // new words are taken while the skid entry is empty
    assign space     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;
    assign main_free = !main_valid_reg || out_ready;

    // buffer update
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (main_free)
        begin
            if (skid_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                main_valid_next = push;
                main_data_next  = push_data;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule

// ===== tb/tb_utf8_to_utf16_stream_decoder_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_to_utf16_stream_decoder_core
// Self-checking bench for the UTF-8 to UTF-16 stream decoder. A short table of
// hand-picked bytes (ASCII limits, stray continuations, invalid leads, every
// sequence length, odd continuation tags, the largest 6-byte point) runs first,
// then ~1350 random bytes, mostly well-formed sequences with random payloads
// mixed with noise and cut-short sequences. A local decoder model, or a table
// literal, predicts each output word; bursty input, patterned output stalls
// and one long output hold exercise the handshakes.
// ----------------------------------------------------------------------------
module tb_utf8_to_utf16_stream_decoder_core;
    import u8d_pkg::*;

    localparam int RANDOM_BYTES   = 1350;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AFTER     = 400;
    localparam int MAX_REPORTS    = 10;
    localparam int DIR_ROWS       = 25;

    // output stall patterns
    typedef enum logic [1:0] {
        RX_STEADY,
        RX_HALF,
        RX_SPARSE,
        RX_TOGGLE
    } rx_mode_e;

    // directed row: byte, literal-check flag, literal word
    typedef struct packed {
        logic [BYTE_W-1:0] b;
        logic              typed;
        result_t           lit;
    } dir_row_t;

    logic clk;
    logic rst_n;

    u8d_in_if  in_ch();
    u8d_out_if out_ch();

    utf8_to_utf16_stream_decoder_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    // columns: byte, typed, code_point, utf16_unit, stray_byte
    dir_row_t directed_rows [DIR_ROWS] = '{
        {8'h00, 1'b1, 31'h00, 16'h0000, 1'b0},
        {8'h7F, 1'b1, 31'h7F, 16'h007F, 1'b0},
        {8'h80, 1'b1, 31'h80, 16'hFF80, 1'b1},
        {8'hFE, 1'b1, 31'hFE, 16'hFFFE, 1'b1},
        {8'hFF, 1'b1, 31'hFF, 16'hFFFF, 1'b1},
        // two bytes
        {8'hC2, 1'b0, 48'h0},
        {8'hA9, 1'b0, 48'h0},
        // three bytes, a lead byte in the continuation slot
        {8'hE2, 1'b0, 48'h0},
        {8'hC2, 1'b0, 48'h0},
        {8'hAC, 1'b0, 48'h0},
        // four bytes, an ASCII byte in the continuation slot
        {8'hF0, 1'b0, 48'h0},
        {8'h9F, 1'b0, 48'h0},
        {8'h58, 1'b0, 48'h0},
        {8'h80, 1'b0, 48'h0},
        // five bytes, an invalid lead in the continuation slot
        {8'hF8, 1'b0, 48'h0},
        {8'hFF, 1'b0, 48'h0},
        {8'h80, 1'b0, 48'h0},
        {8'h80, 1'b0, 48'h0},
        {8'h80, 1'b0, 48'h0},
        // six bytes, all payload ones: largest point, unit truncated
        {8'hFD, 1'b0, 48'h0},
        {8'hBF, 1'b0, 48'h0},
        {8'hBF, 1'b0, 48'h0},
        {8'hBF, 1'b0, 48'h0},
        {8'hBF, 1'b0, 48'h0},
        {8'hBF, 1'b1, 31'h7FFFFFFF, 16'hFFFF, 1'b0}
    };

    // decoder model state
    logic [CP_W-1:0]   dec_partial;
    logic [LEFT_W-1:0] dec_left;

    result_t pending_points [$];

    // side data that travels with the word on the input channel
    logic    drv_typed;
    result_t drv_lit;

    int fail_cnt;
    int cycle_cnt;
    int bytes_in;
    int words_out;
    int stray_out;
    int wide_out;
    int in_stall_cycles;
    int random_bytes;
    int burst_left;

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // one decoder step on the model state; returns 1 when a word comes out
    function automatic logic decode_byte(input logic [BYTE_W-1:0] b, output result_t r);
        int  ones;
        logic emit;
        r    = '0;
        emit = 1'b0;
        if (dec_left != '0)
        begin
            dec_partial = {dec_partial[CP_W-CONT_BITS-1:0], b[CONT_BITS-1:0]};
            dec_left    = dec_left - 1'b1;
            if (dec_left == '0)
            begin
                r.code_point = dec_partial;
                r.utf16_unit = dec_partial[UNIT_W-1:0];
                emit         = 1'b1;
                dec_partial  = '0;
            end
        end
        else
        begin
            ones = 0;
            while (ones < BYTE_W && b[BYTE_W-1-ones])
                ones++;
            if (ones == ONES_ASCII)
            begin
                r.code_point = CP_W'(b);
                r.utf16_unit = UNIT_W'(b);
                emit         = 1'b1;
            end
            else if (ones == ONES_CONT || ones >= ONES_INVALID)
            begin
                r.code_point = CP_W'(b);
                r.utf16_unit = STRAY_UNIT_HIGH | UNIT_W'(b);
                r.stray_byte = 1'b1;
                emit         = 1'b1;
            end
            else
            begin
                dec_partial = CP_W'(b & (LEAD_PAYLOAD >> ones));
                dec_left    = LEFT_W'(ones - 1);
            end
        end
        return emit;
    endfunction

    // offer one byte, with bursty gaps, and wait for it to be taken
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic typed, input result_t lit);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                @(negedge clk);
                in_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        drv_typed     <= typed;
        drv_lit       <= lit;
        @(posedge clk);
        while (!(in_ch.valid && in_ch.ready))
            @(posedge clk);
    endtask

    // random bytes: mostly well-formed sequences, some noise and cut-short runs
    task automatic send_random_stream();
        int kind;
        int pick;
        int len;
        int cut;
        int i;
        logic [BYTE_W-1:0] lead;
        while (random_bytes < RANDOM_BYTES)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 15)
            begin
                send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0, '0);
                random_bytes++;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                len  = (pick < 30) ? 1 : (pick < 50) ? 2 : (pick < 70) ? 3 :
                       (pick < 85) ? 4 : (pick < 93) ? 5 : 6;
                if (len == 1)
                    lead = BYTE_W'($urandom_range(0, 127));
                else
                    lead = BYTE_W'(8'hFF << (8 - len)) |
                           (BYTE_W'($urandom) & (LEAD_PAYLOAD >> len));
                cut = len;
                if (kind >= 85 && len > 1)
                    cut = $urandom_range(1, len - 1);
                send_byte(lead, 1'b0, '0);
                for (i = 1; i < cut; i++)
                    send_byte(8'h80 | BYTE_W'($urandom_range(0, 63)), 1'b0, '0);
                random_bytes += cut;
            end
        end
    endtask

    // scoreboard: check output words, predict on accepted input words
    always @(posedge clk)
    begin
        result_t want;
        result_t got;
        logic    emit;
        if (rst_n)
        begin
            if (in_ch.valid && !in_ch.ready)
                in_stall_cycles++;
            if (out_ch.valid && out_ch.ready)
            begin
                got.code_point = out_ch.code_point;
                got.utf16_unit = out_ch.utf16_unit;
                got.stray_byte = out_ch.stray_byte;
                words_out++;
                if (got.stray_byte === 1'b1)
                    stray_out++;
                if (got.code_point > 31'hFFFF)
                    wide_out++;
                if (pending_points.size() == 0)
                begin
                    fail_cnt++;
                    if (fail_cnt <= MAX_REPORTS)
                        $display("[%0t] unexpected word: cp=%h unit=%h stray=%b",
                                 $realtime, got.code_point, got.utf16_unit, got.stray_byte);
                end
                else
                begin
                    want = pending_points.pop_front();
                    if (got.code_point !== want.code_point ||
                        got.utf16_unit !== want.utf16_unit ||
                        got.stray_byte !== want.stray_byte)
                    begin
                        fail_cnt++;
                        if (fail_cnt <= MAX_REPORTS)
                            $display({"[%0t] word mismatch: exp cp=%h unit=%h stray=%b,",
                                      " got cp=%h unit=%h stray=%b"},
                                     $realtime, want.code_point, want.utf16_unit,
                                     want.stray_byte, got.code_point, got.utf16_unit,
                                     got.stray_byte);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready)
            begin
                bytes_in++;
                emit = decode_byte(in_ch.in_byte, want);
                if (emit)
                    pending_points.insert(pending_points.size(), drv_typed ? drv_lit : want);
            end
        end
    end

    // output stall patterns, plus one long hold so the input backs up
    initial
    begin
        rx_mode_e mode;
        int       len;
        int       i;
        logic     hold_done;
        out_ch.ready = 1'b0;
        hold_done    = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!hold_done && bytes_in >= HOLD_AFTER)
            begin
                @(negedge clk);
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                mode = rx_mode_e'($urandom_range(0, 3));
                len  = $urandom_range(20, 80);
                for (i = 0; i < len; i++)
                begin
                    @(negedge clk);
                    case (mode)
                        RX_STEADY: out_ch.ready <= 1'b1;
                        RX_HALF:   out_ch.ready <= 1'($urandom_range(0, 1));
                        RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
                        default:   out_ch.ready <= i[0];
                    endcase
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d words pending",
                     cycle_cnt, pending_points.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // reset, stimulus, drain and verdict
    initial
    begin
        int i;
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.in_byte   = '0;
        drv_typed       = 1'b0;
        drv_lit         = '0;
        dec_partial     = '0;
        dec_left        = '0;
        fail_cnt        = 0;
        cycle_cnt       = 0;
        bytes_in        = 0;
        words_out       = 0;
        stray_out       = 0;
        wide_out        = 0;
        in_stall_cycles = 0;
        random_bytes    = 0;
        burst_left      = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < DIR_ROWS; i++)
            send_byte(directed_rows[i].b, directed_rows[i].typed, directed_rows[i].lit);

        send_random_stream();

        // a sequence cut off at end of stream gives no word
        send_byte(8'hE2, 1'b0, '0);
        send_byte(8'h82, 1'b0, '0);
        @(negedge clk);
        in_ch.valid <= 1'b0;

        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending_points.size() != 0)
        begin
            fail_cnt++;
            $display("%0d expected words never arrived", pending_points.size());
        end

        $display("coverage: %0d bytes in (%0d table rows), %0d words out",
                 bytes_in, DIR_ROWS, words_out);
        $display("coverage: %0d stray, %0d above 0xFFFF, input stalled %0d cycles",
                 stray_out, wide_out, in_stall_cycles);
        $display("coverage: one %0d-cycle output hold, %0d failures",
                 HOLD_CYCLES, fail_cnt);
        if (fail_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
